### rtl/cabn_pkg.sv
// Shared types and constants for the class-aware box suppression block.
`timescale 1ns / 1ps
`default_nettype none
package cabn_pkg;
	localparam int MAX_BOXES_DEF = 64;
	localparam logic [15:0] IOU_THRESHOLD_RST = 16'd29491;

	typedef struct packed {
		logic [7:0]         class_id;
		logic [15:0]        score;
		logic [19:0]        height;
		logic [19:0]        width;
		logic signed [19:0] top;
		logic signed [19:0] left;
	} box_t;

	localparam int BOX_W = $bits(box_t);
endpackage
`default_nettype wire

### rtl/cabn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cabn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/class_aware_box_nms.sv
// Top level of the class-aware box non-maximum suppression block.
`timescale 1ns / 1ps
`default_nettype none
// Boxes stream in one item per cycle and are written to a box RAM. The item
// marked tlast starts suppression: for each stored box the block reads it
// once, then streams every stored box past it through a compare pipeline
// (one RAM read per cycle), all through the single read port of the box RAM.
// Keep flags go to a second RAM and are then sent out one result item at a
// time, in load order, each with the set's kept count; the next item is read
// only after the receiver has taken the last. Boxes beyond MAX_BOXES are
// dropped. No item is accepted while suppression or result output is under
// way.
module class_aware_box_nms
	import cabn_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// Fields from bit 0: box_left, box_top, box_width, box_height, score, class_id.
	input  wire logic [103:0] s_axis_tdata,
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// Fields from bit 0: box_index[5:0], keep[6], kept_count[13:7], zero fill.
	output logic [15:0]       m_axis_tdata,
	output logic              m_axis_tlast
);
	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_ORD      = 4'd1;
	localparam logic [3:0] ST_OWAIT    = 4'd2;
	localparam logic [3:0] ST_RUN      = 4'd3;
	localparam logic [3:0] ST_DRAIN    = 4'd4;
	localparam logic [3:0] ST_OUT_RD   = 4'd5;
	localparam logic [3:0] ST_OUT_WAIT = 4'd6;
	localparam logic [3:0] ST_OUT_HOLD = 4'd7;

	logic [3:0]    state_q;
	logic [15:0]   thr_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] kept_q;
	logic [IW-1:0] oi_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;
	logic          acc_q;
	box_t          cur_q;
	logic [39:0]   ai_q;

	logic          box_we;
	logic [IW-1:0] box_raddr;
	box_t          box_wdata;
	logic [BOX_W-1:0] box_rdata;
	box_t          oth;
	logic          keep_we;
	logic [IW-1:0] keep_raddr;
	logic [0:0]    keep_rdata;

	logic          full;
	logic          in_acc;
	logic [CW-1:0] n_last;
	logic          pipe_busy;
	logic [IW-1:0] n_m1;

	assign full       = (cnt_q == CW'(MAX_BOXES));
	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign n_last     = full ? cnt_q : cnt_q + CW'(1);
	assign n_m1       = IW'(n_q - CW'(1));
	assign cfg_ready  = 1'b1;
	assign s_axis_tready = (state_q == ST_LOAD);

	assign box_wdata  = box_t'(s_axis_tdata);
	assign box_we     = in_acc && !full;
	assign box_raddr  = (state_q == ST_RUN) ? j_q : oi_q;
	assign oth        = box_t'(box_rdata);
	assign keep_we    = (state_q == ST_DRAIN) && !pipe_busy;
	assign keep_raddr = k_q;

	cabn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (box_wdata),
		.raddr (box_raddr),
		.rdata (box_rdata)
	);

	cabn_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_keep_ram (
		.clk   (clk),
		.we    (keep_we),
		.waddr (oi_q),
		.wdata (!acc_q),
		.raddr (keep_raddr),
		.rdata (keep_rdata)
	);

	// Stage 1: candidate test and clipped overlap extents from the RAM data.
	logic              v_s1;
	logic [IW-1:0]     j_s1;
	logic signed [21:0] li, lj, ti, tj, ri, rj, bi, bj, iw_raw, ih_raw;
	logic [19:0]       iw_c, ih_c;
	logic              cand;

	always_comb begin
		li = {{2{cur_q.left[19]}}, cur_q.left};
		lj = {{2{oth.left[19]}}, oth.left};
		ti = {{2{cur_q.top[19]}}, cur_q.top};
		tj = {{2{oth.top[19]}}, oth.top};
		ri = li + $signed({2'b00, cur_q.width});
		rj = lj + $signed({2'b00, oth.width});
		bi = ti + $signed({2'b00, cur_q.height});
		bj = tj + $signed({2'b00, oth.height});
		iw_raw = ((ri < rj) ? ri : rj) - ((li > lj) ? li : lj);
		ih_raw = ((bi < bj) ? bi : bj) - ((ti > tj) ? ti : tj);
		iw_c = iw_raw[21] ? 20'd0 : iw_raw[19:0];
		ih_c = ih_raw[21] ? 20'd0 : ih_raw[19:0];
		cand = (j_s1 != oi_q) && (oth.class_id == cur_q.class_id)
			&& ((oth.score > cur_q.score) || ((oth.score == cur_q.score) && (j_s1 > oi_q)));
	end

	logic        v_s2, v_s3, v_s4, v_s5;
	logic        c_s2, c_s3, c_s4, c_s5;
	logic [19:0] iw_s2, ih_s2, wj_s2, hj_s2;
	logic [39:0] inter_s3, aj_s3, inter_s4;
	logic [40:0] uni_s4;
	logic [39:0] inter_s5;
	logic [36:0] plo_s5;
	logic [35:0] phi_s5;
	logic        nz_s5;
	logic [57:0] lhs, rhs;
	logic        hit;

	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;

	// Final compare of inter*65536 against threshold*union.
	always_comb begin
		lhs = {2'b00, inter_s5, 16'd0};
		rhs = 58'(plo_s5) + {1'b0, phi_s5, 21'd0};
		hit = c_s5 && nz_s5 && (lhs > rhs);
	end

	// Datapath stages 2 to 5: products, union, threshold partial products.
	always_ff @(posedge clk) begin
		iw_s2    <= iw_c;
		ih_s2    <= ih_c;
		wj_s2    <= oth.width;
		hj_s2    <= oth.height;
		c_s2     <= cand;
		inter_s3 <= iw_s2 * ih_s2;
		aj_s3    <= wj_s2 * hj_s2;
		c_s3     <= c_s2;
		uni_s4   <= {1'b0, ai_q} + {1'b0, aj_s3} - {1'b0, inter_s3};
		inter_s4 <= inter_s3;
		c_s4     <= c_s3;
		plo_s5   <= thr_q * uni_s4[20:0];
		phi_s5   <= thr_q * uni_s4[40:21];
		nz_s5    <= (uni_s4 != 41'd0);
		inter_s5 <= inter_s4;
		c_s5     <= c_s4;
		ai_q     <= cur_q.width * cur_q.height;
		if (state_q == ST_OWAIT) begin
			cur_q <= oth;
		end
		if (state_q == ST_RUN) begin
			j_s1 <= j_q;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IOU_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Sequencer for loading, suppression and result output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			cnt_q         <= '0;
			n_q           <= '0;
			kept_q        <= '0;
			oi_q          <= '0;
			j_q           <= '0;
			k_q           <= '0;
			acc_q         <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (v_s5 && hit) begin
				acc_q <= 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (!full) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (s_axis_tlast) begin
							n_q     <= n_last;
							kept_q  <= n_last;
							oi_q    <= '0;
							state_q <= ST_ORD;
						end
					end
				end
				ST_ORD: begin
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					acc_q   <= 1'b0;
					j_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (j_q == n_m1) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						kept_q <= kept_q - CW'(acc_q);
						if (oi_q == n_m1) begin
							k_q     <= '0;
							state_q <= ST_OUT_RD;
						end else begin
							oi_q    <= oi_q + IW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					m_axis_tvalid       <= 1'b1;
					m_axis_tdata[5:0]   <= 6'(k_q);
					m_axis_tdata[6]     <= keep_rdata[0];
					m_axis_tdata[13:7]  <= 7'(kept_q);
					m_axis_tlast        <= (k_q == n_m1);
					state_q             <= ST_OUT_HOLD;
				end
				ST_OUT_HOLD: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						if (k_q == n_m1) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/cabn_checker.sv
// Port-level checker for the suppression block, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module cabn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	// Loading and result output never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while a result item is pending");

	// A stalled result item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result item changed");

	// After the final result of a set the block returns to loading.
	a_set_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
		else $error("block did not return to loading after the final result");
endmodule

bind class_aware_box_nms cabn_checker u_cabn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### test/tb_class_aware_box_nms.sv
// Testbench for the class-aware box non-maximum suppression block.
`timescale 1ns / 1ps
module tb_class_aware_box_nms;
	import cabn_pkg::*;

	localparam int NBOX = MAX_BOXES_DEF;

	typedef struct {
		logic [5:0] idx;
		logic       keep;
		logic [6:0] kept;
		logic       last;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tlast;

	// Predictor state: threshold and the boxes of the set being loaded.
	logic [15:0] thresh = IOU_THRESHOLD_RST;
	box_t set_boxes[NBOX];
	int set_len = 0;
	verdict_t verdict_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;

	always #10 clk = ~clk;

	class_aware_box_nms dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// True when box b suppresses box a by overlap.
	function automatic bit overlap_exceeds(box_t a, box_t b);
		longint al, at, bl, bt, aw, ah, bw, bh, iw, ih, inter, uni;
		al = a.left; at = a.top; bl = b.left; bt = b.top;
		aw = a.width; ah = a.height; bw = b.width; bh = b.height;
		iw = ((al + aw < bl + bw) ? al + aw : bl + bw) - ((al > bl) ? al : bl);
		ih = ((at + ah < bt + bh) ? at + ah : bt + bh) - ((at > bt) ? at : bt);
		if (iw < 0) iw = 0;
		if (ih < 0) ih = 0;
		inter = iw * ih;
		uni = aw * ah + bw * bh - inter;
		if (uni <= 0)
			return 1'b0;
		return inter * 65536 > longint'(thresh) * uni;
	endfunction

	// Run suppression over the stored set and queue one verdict per box.
	task automatic predict_set();
		bit kept_flag[NBOX];
		int total;
		verdict_t v;
		total = set_len;
		for (int i = 0; i < set_len; i++) begin
			kept_flag[i] = 1'b1;
			for (int j = 0; j < set_len; j++) begin
				if (j == i || set_boxes[j].class_id != set_boxes[i].class_id) continue;
				if (set_boxes[j].score < set_boxes[i].score) continue;
				if (set_boxes[j].score == set_boxes[i].score && j < i) continue;
				if (overlap_exceeds(set_boxes[i], set_boxes[j])) begin
					kept_flag[i] = 1'b0;
					total--;
					break;
				end
			end
		end
		for (int k = 0; k < set_len; k++) begin
			v.idx = k[5:0];
			v.keep = kept_flag[k];
			v.kept = total[6:0];
			v.last = (k + 1 == set_len);
			verdict_q = {verdict_q, v};
		end
		set_len = 0;
	endtask

	// Send one box item, with random idle cycles before it. The valid line
	// stays high after acceptance so that items can follow back to back.
	task automatic send_box(box_t b, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (set_len < NBOX) begin
			set_boxes[set_len] = b;
			set_len++;
		end
		if (last) predict_set();
	endtask

	// Wait for every expected result, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		thresh = val;
	endtask

	function automatic box_t make_box(int l, int t, int w, int h, int sc, int cl);
		box_t b;
		b.left = 20'(l); b.top = 20'(t); b.width = 20'(w); b.height = 20'(h);
		b.score = 16'(sc); b.class_id = 8'(cl);
		return b;
	endfunction

	// Random box near a cluster so that overlaps and classes collide often.
	function automatic box_t random_box(int cx, int cy);
		box_t b;
		if ($urandom_range(9) == 0) begin
			b = BOX_W'({$urandom, $urandom, $urandom, $urandom});
		end else begin
			b.left = 20'(cx + $urandom_range(160) - 80);
			b.top = 20'(cy + $urandom_range(160) - 80);
			b.width = 20'($urandom_range(400));
			b.height = 20'($urandom_range(400));
			b.score = ($urandom_range(3) == 0) ? 16'h8000 : 16'($urandom);
			b.class_id = 8'($urandom_range(2));
		end
		return b;
	endfunction

	// Result checker: compare each accepted result with the oldest verdict.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item data=%h last=%b", m_axis_tdata, m_axis_tlast);
			end else begin
				verdict_t v;
				v = verdict_q.pop_front();
				if (m_axis_tdata[5:0] !== v.idx || m_axis_tdata[6] !== v.keep
					|| m_axis_tdata[13:7] !== v.kept || m_axis_tlast !== v.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected idx=%0d keep=%b kept=%0d ",
							"last=%b, got idx=%0d keep=%b kept=%0d last=%b"},
							v.idx, v.keep, v.kept, v.last, m_axis_tdata[5:0],
							m_axis_tdata[6], m_axis_tdata[13:7], m_axis_tlast);
				end
			end
		end
	end

	// Receiver ready with random stalls.
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Directed sets: field extremes, ties, degenerate unions, single box.
	task automatic test_directed();
		send_box(make_box(0, 0, 0, 0, 0, 0), 1'b1);
		send_box(make_box(0, 0, 160, 160, 100, 5), 1'b0);
		send_box(make_box(16, 16, 160, 160, 200, 5), 1'b0);
		send_box(make_box(0, 0, 160, 160, 100, 6), 1'b0);
		send_box(make_box(0, 0, 160, 160, 100, 5), 1'b0);
		send_box(make_box(-524288, -524288, 1048575, 1048575, 65535, 255), 1'b0);
		send_box(make_box(524287, 524287, 1048575, 1048575, 65535, 255), 1'b0);
		send_box(make_box(-524288, -524288, 1048575, 1048575, 65535, 255), 1'b0);
		send_box(make_box(5, 5, 0, 0, 7, 1), 1'b0);
		send_box(make_box(5, 5, 0, 0, 7, 1), 1'b1);
		drain();
	endtask

	// Threshold extremes on a small overlapping set.
	task automatic test_thresholds();
		int vals[3] = '{0, 65535, 32768};
		foreach (vals[i]) begin
			write_threshold(16'(vals[i]));
			for (int k = 0; k < 4; k++)
				send_box(make_box(k * 8, k * 8, 160, 160, 1000 - k, 3), k == 3);
			drain();
		end
	endtask

	// Overfull set: boxes past the store size are dropped.
	task automatic test_overflow();
		for (int k = 0; k < NBOX + 3; k++)
			send_box(random_box(0, 0), k == NBOX + 2);
		drain();
	endtask

	// Random sets under one idle profile.
	task automatic test_random(int sidle, int ridle, int count);
		int n, cx, cy;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		while (count > 0) begin
			n = $urandom_range(8, 1);
			cx = $urandom_range(2000) - 1000;
			cy = $urandom_range(2000) - 1000;
			for (int k = 0; k < n; k++)
				send_box(random_box(cx, cy), k == n - 1);
			count -= n;
		end
		drain();
		write_threshold(16'($urandom));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_thresholds();
		write_threshold(IOU_THRESHOLD_RST);
		test_overflow();
		test_random(16, 80, 10);
		test_random(80, 16, 10);
		test_random(0, 0, 10);
		drain();
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

### filelist.f
rtl/cabn_pkg.sv
rtl/cabn_ram.sv
rtl/class_aware_box_nms.sv
rtl/cabn_checker.sv
test/tb_class_aware_box_nms.sv
